[hdl/grtc_pkg.sv]
// ----------------------------------------------------------------------------
// grtc_pkg
// Shared types, widths and constants for the geometric rate torque controller.
// ----------------------------------------------------------------------------
package grtc_pkg;

  localparam int NUM_AXES = 3;
  localparam int NUM_REGS = 7;
  localparam int CFG_W    = 24;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(NUM_REGS * 4);
  localparam int REG_W    = ADDR_W - 2;

  localparam int RATE_W   = 16;
  localparam int DRIVE_W  = 12;
  localparam int DRIVE_LIMIT = 2000;

  // rad/s per input LSB, Q.32
  localparam int K_W = 25;
  localparam logic signed [K_W-1:0] RAD_PER_LSB = 25'sd4685083;

  localparam int RATE_SH  = 16;
  localparam int INER_SH  = 24;
  localparam int CROSS_SH = 8;
  localparam int GAIN_SH  = 12;
  localparam int OUT_SH   = 32;

  localparam int GK_W  = RATE_W + K_W;
  localparam int W_W   = GK_W - RATE_SH;
  localparam int EK_W  = RATE_W + 1 + K_W;
  localparam int E_W   = EK_W - RATE_SH;
  localparam int HP_W  = W_W + CFG_W + 1;
  localparam int H_W   = HP_W - INER_SH;
  localparam int GP_W  = E_W + CFG_W + 1;
  localparam int GT_W  = GP_W - GAIN_SH;
  localparam int CP_W  = W_W + H_W;
  localparam int CD_W  = CP_W + 1;
  localparam int CR_W  = CD_W - CROSS_SH;
  localparam int TQ_W  = CR_W + 1;
  localparam int LO_W  = TQ_W / 2;
  localparam int HI_W  = TQ_W - LO_W;
  localparam int PL_W  = LO_W + CFG_W;
  localparam int PH_W  = HI_W + CFG_W + 1;
  localparam int SUM_W = TQ_W + CFG_W + 1;
  localparam int RND_W = SUM_W - OUT_SH;

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(64'h8000_0000);

  localparam logic signed [DRIVE_W-1:0] DRV_MAX = DRIVE_W'(DRIVE_LIMIT);
  localparam logic signed [DRIVE_W-1:0] DRV_MIN = -DRV_MAX;

  typedef enum logic [REG_W-1:0] {
    REG_GAIN_ROLL     = 3'd0,
    REG_GAIN_PITCH    = 3'd1,
    REG_GAIN_YAW      = 3'd2,
    REG_INERTIA_ROLL  = 3'd3,
    REG_INERTIA_PITCH = 3'd4,
    REG_INERTIA_YAW   = 3'd5,
    REG_TORQUE_SCALE  = 3'd6
  } reg_idx_t;

  localparam logic [CFG_W-1:0] GAIN_RST      = 24'd0;
  localparam logic [CFG_W-1:0] INERTIA_RP_RST = 24'd50332;
  localparam logic [CFG_W-1:0] INERTIA_Y_RST  = 24'd83886;
  localparam logic [CFG_W-1:0] SCALE_RST     = 24'd5120000;

  typedef struct packed {
    logic [NUM_AXES-1:0][CFG_W-1:0] gain;
    logic [NUM_AXES-1:0][CFG_W-1:0] inertia;
    logic [CFG_W-1:0]               scale;
  } cfg_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][W_W-1:0]  w;
    logic [NUM_AXES-1:0][HP_W-1:0] hp;
    logic [NUM_AXES-1:0][GP_W-1:0] gp;
  } rate_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][TQ_W-1:0] tq;
  } torque_t;

endpackage

[hdl/grtc_regs.sv]
// ----------------------------------------------------------------------------
// grtc_regs
// APB register file holding gains, inertias and the torque scale.
// ----------------------------------------------------------------------------
module grtc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [grtc_pkg::ADDR_W-1:0]   paddr,
  input  logic [grtc_pkg::DATA_W-1:0]   pwdata,
  output logic [grtc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output grtc_pkg::cfg_t                cfg
);
  import grtc_pkg::*;

  reg_idx_t         idx;
  logic             wr;
  logic [CFG_W-1:0] wval;
  logic [CFG_W-1:0] rval;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite & pready;
  assign wval   = pwdata[CFG_W-1:0];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain    <= {NUM_AXES{GAIN_RST}};
      cfg.inertia <= {INERTIA_Y_RST, INERTIA_RP_RST, INERTIA_RP_RST};
      cfg.scale   <= SCALE_RST;
    end else if (wr) begin
      case (idx)
        REG_GAIN_ROLL:     cfg.gain[0]    <= wval;
        REG_GAIN_PITCH:    cfg.gain[1]    <= wval;
        REG_GAIN_YAW:      cfg.gain[2]    <= wval;
        REG_INERTIA_ROLL:  cfg.inertia[0] <= wval;
        REG_INERTIA_PITCH: cfg.inertia[1] <= wval;
        REG_INERTIA_YAW:   cfg.inertia[2] <= wval;
        REG_TORQUE_SCALE:  cfg.scale      <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_ROLL:     rval = cfg.gain[0];
      REG_GAIN_PITCH:    rval = cfg.gain[1];
      REG_GAIN_YAW:      rval = cfg.gain[2];
      REG_INERTIA_ROLL:  rval = cfg.inertia[0];
      REG_INERTIA_PITCH: rval = cfg.inertia[1];
      REG_INERTIA_YAW:   rval = cfg.inertia[2];
      REG_TORQUE_SCALE:  rval = cfg.scale;
      default:           rval = '0;
    endcase
  end

  assign prdata = DATA_W'(rval);

endmodule

[hdl/grtc_rate.sv]
// ----------------------------------------------------------------------------
// grtc_rate
// Stages 1-2: rate and error conversion to rad/s, angular momentum and
// gain products.
// ----------------------------------------------------------------------------
module grtc_rate (
  input  logic                                               clk,
  input  logic                                               rst,
  input  grtc_pkg::cfg_t                                     cfg,
  input  logic                                               in_valid,
  output logic                                               in_ready,
  input  logic [grtc_pkg::NUM_AXES-1:0][grtc_pkg::RATE_W-1:0] gyro,
  input  logic [grtc_pkg::NUM_AXES-1:0][grtc_pkg::RATE_W-1:0] target,
  output logic                                               out_valid,
  input  logic                                               out_ready,
  output grtc_pkg::rate_t                                    out_data
);
  import grtc_pkg::*;

  logic v1, v2;
  logic rdy1, rdy2;

  logic [NUM_AXES-1:0][GK_W-1:0] gk, gk_next;
  logic [NUM_AXES-1:0][EK_W-1:0] ek, ek_next;
  rate_t                         data_next;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v2;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      gk_next[a] = GK_W'($signed(gyro[a])) * GK_W'(RAD_PER_LSB);
      ek_next[a] = (EK_W'($signed(gyro[a])) - EK_W'($signed(target[a])))
                   * EK_W'(RAD_PER_LSB);
      data_next.w[a]  = gk[a][GK_W-1:RATE_SH];
      data_next.hp[a] = HP_W'($signed(data_next.w[a]))
                        * HP_W'($signed({1'b0, cfg.inertia[a]}));
      data_next.gp[a] = GP_W'($signed(ek[a][EK_W-1:RATE_SH]))
                        * GP_W'($signed({1'b0, cfg.gain[a]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      gk <= gk_next;
      ek <= ek_next;
    end
    if (rdy2 && v1) begin
      out_data <= data_next;
    end
  end

endmodule

[hdl/grtc_torque.sv]
// ----------------------------------------------------------------------------
// grtc_torque
// Stages 3-5: gyroscopic cross products, their difference, and the torque
// as cross term minus gain term.
// ----------------------------------------------------------------------------
module grtc_torque (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  grtc_pkg::rate_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output grtc_pkg::torque_t out_data
);
  import grtc_pkg::*;

  function automatic int next_axis(int a);
    return (a == NUM_AXES - 1) ? 0 : a + 1;
  endfunction

  function automatic int prev_axis(int a);
    return (a == 0) ? NUM_AXES - 1 : a - 1;
  endfunction

  logic v3, v4, v5;
  logic rdy3, rdy4, rdy5;

  logic [NUM_AXES-1:0][H_W-1:0]  h;
  logic [NUM_AXES-1:0][CP_W-1:0] cpa, cpa_next, cpb, cpb_next;
  logic [NUM_AXES-1:0][GT_W-1:0] gt3, gt3_next, gt4;
  logic [NUM_AXES-1:0][CD_W-1:0] cd, cd_next;
  torque_t                       data_next;

  assign rdy5      = !v5 || out_ready;
  assign rdy4      = !v4 || rdy5;
  assign rdy3      = !v3 || rdy4;
  assign in_ready  = rdy3;
  assign out_valid = v5;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      h[a] = in_data.hp[a][HP_W-1:INER_SH];
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      // w_i*h_j - w_j*h_i, (i,j) the two following axes
      cpa_next[a] = CP_W'($signed(in_data.w[next_axis(a)]))
                    * CP_W'($signed(h[prev_axis(a)]));
      cpb_next[a] = CP_W'($signed(in_data.w[prev_axis(a)]))
                    * CP_W'($signed(h[next_axis(a)]));
      gt3_next[a] = in_data.gp[a][GP_W-1:GAIN_SH];
      cd_next[a]  = CD_W'($signed(cpa[a])) - CD_W'($signed(cpb[a]));
      data_next.tq[a] = TQ_W'($signed(cd[a][CD_W-1:CROSS_SH]))
                        - TQ_W'($signed(gt4[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy3) v3 <= in_valid;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      cpa <= cpa_next;
      cpb <= cpb_next;
      gt3 <= gt3_next;
    end
    if (rdy4 && v3) begin
      cd  <= cd_next;
      gt4 <= gt3;
    end
    if (rdy5 && v4) begin
      out_data <= data_next;
    end
  end

endmodule

[hdl/grtc_drive.sv]
// ----------------------------------------------------------------------------
// grtc_drive
// Stages 6-7: torque times mixer scale in two partial products, round to
// nearest (ties away from zero) and saturate with per-axis flags.
// ----------------------------------------------------------------------------
module grtc_drive (
  input  logic                                                clk,
  input  logic                                                rst,
  input  grtc_pkg::cfg_t                                      cfg,
  input  logic                                                in_valid,
  output logic                                                in_ready,
  input  grtc_pkg::torque_t                                   in_data,
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output logic [grtc_pkg::NUM_AXES-1:0][grtc_pkg::DRIVE_W-1:0] drive,
  output logic [grtc_pkg::NUM_AXES-1:0]                       flags
);
  import grtc_pkg::*;

  localparam logic signed [RND_W-1:0] LIM_HI = RND_W'(DRIVE_LIMIT);
  localparam logic signed [RND_W-1:0] LIM_LO = -LIM_HI;

  logic v6, v7;
  logic rdy6, rdy7;

  logic [NUM_AXES-1:0][PL_W-1:0]    pl, pl_next;
  logic [NUM_AXES-1:0][PH_W-1:0]    ph, ph_next;
  logic [NUM_AXES-1:0][SUM_W-1:0]   sum;
  logic [NUM_AXES-1:0][SUM_W-1:0]   rc;
  logic [NUM_AXES-1:0][RND_W-1:0]   r;
  logic [NUM_AXES-1:0][DRIVE_W-1:0] drive_next;
  logic [NUM_AXES-1:0]              flags_next;

  assign rdy7      = !v7 || out_ready;
  assign rdy6      = !v6 || rdy7;
  assign in_ready  = rdy6;
  assign out_valid = v7;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      pl_next[a] = PL_W'(in_data.tq[a][LO_W-1:0]) * PL_W'(cfg.scale);
      ph_next[a] = PH_W'($signed(in_data.tq[a][TQ_W-1:LO_W]))
                   * PH_W'($signed({1'b0, cfg.scale}));
      // negative product: ceil of (P - half) == floor of (P + half - 1)
      rc[a]  = ph[a][PH_W-1] ? ROUND_HALF - SUM_W'(1) : ROUND_HALF;
      sum[a] = (SUM_W'($signed(ph[a])) << LO_W) + SUM_W'(pl[a]) + rc[a];
      r[a]   = sum[a][SUM_W-1:OUT_SH];
      if ($signed(r[a]) > LIM_HI) begin
        drive_next[a] = DRV_MAX;
        flags_next[a] = 1'b1;
      end else if ($signed(r[a]) < LIM_LO) begin
        drive_next[a] = DRV_MIN;
        flags_next[a] = 1'b1;
      end else begin
        drive_next[a] = r[a][DRIVE_W-1:0];
        flags_next[a] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy6) v6 <= in_valid;
      if (rdy7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6 && in_valid) begin
      pl <= pl_next;
      ph <= ph_next;
    end
    if (rdy7 && v6) begin
      drive <= drive_next;
      flags <= flags_next;
    end
  end

`ifndef ASSERT_OFF
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_chk
    a_drive_range: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (flags[a] ?
        ($signed(drive[a]) == DRV_MAX || $signed(drive[a]) == DRV_MIN) :
        ($signed(drive[a]) <= DRV_MAX && $signed(drive[a]) >= DRV_MIN)))
      else $error("drive out of range or flag mismatch");
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !v6)
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    v6 && out_valid && !out_ready |=> v6)
    else $error("stalled transaction dropped from scale stage");
`endif

endmodule

[hdl/geometric_rate_torque_control_core.sv]
// Pipeline: seven register stages from input transaction to result valid:
// conversion, momentum/gain products, cross products, difference, torque,
// scale partial products, round and saturate. Reset: clears all stage valid
// bits and restores register defaults. Throughput: one transaction per
// cycle while out_ready is high; per-stage valid bits fill bubbles.
// ----------------------------------------------------------------------------
// geometric_rate_torque_control_core
// Body-rate controller with gyroscopic feed-forward: rate error gain plus
// omega x (J omega), scaled to mixer units and saturated to +/-2000.
// ----------------------------------------------------------------------------
module geometric_rate_torque_control_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [grtc_pkg::ADDR_W-1:0]           paddr,
  input  logic [grtc_pkg::DATA_W-1:0]           pwdata,
  output logic [grtc_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [grtc_pkg::RATE_W-1:0]    gyro_roll,
  input  logic signed [grtc_pkg::RATE_W-1:0]    gyro_pitch,
  input  logic signed [grtc_pkg::RATE_W-1:0]    gyro_yaw,
  input  logic signed [grtc_pkg::RATE_W-1:0]    target_roll,
  input  logic signed [grtc_pkg::RATE_W-1:0]    target_pitch,
  input  logic signed [grtc_pkg::RATE_W-1:0]    target_yaw,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [grtc_pkg::DRIVE_W-1:0]   drive_roll,
  output logic signed [grtc_pkg::DRIVE_W-1:0]   drive_pitch,
  output logic signed [grtc_pkg::DRIVE_W-1:0]   drive_yaw,
  output logic [grtc_pkg::NUM_AXES-1:0]         clamp_flags
);
  import grtc_pkg::*;

  cfg_t    cfg;
  rate_t   rate_data;
  torque_t tq_data;
  logic    rate_valid, rate_ready;
  logic    tq_valid, tq_ready;

  logic [NUM_AXES-1:0][RATE_W-1:0]  gyro, target;
  logic [NUM_AXES-1:0][DRIVE_W-1:0] drive;

  assign gyro   = {gyro_yaw, gyro_pitch, gyro_roll};
  assign target = {target_yaw, target_pitch, target_roll};

  grtc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  grtc_rate u_rate (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .gyro      (gyro),
    .target    (target),
    .out_valid (rate_valid),
    .out_ready (rate_ready),
    .out_data  (rate_data)
  );

  grtc_torque u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rate_valid),
    .in_ready  (rate_ready),
    .in_data   (rate_data),
    .out_valid (tq_valid),
    .out_ready (tq_ready),
    .out_data  (tq_data)
  );

  grtc_drive u_drive (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (tq_valid),
    .in_ready  (tq_ready),
    .in_data   (tq_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .flags     (clamp_flags)
  );

  assign drive_roll  = drive[0];
  assign drive_pitch = drive[1];
  assign drive_yaw   = drive[2];

endmodule
